// ===== hw/rtl/bcsrs_pkg.sv =====
// shared types and codes for the bit column set row scanner
`default_nettype none

package bcsrs_pkg;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // result kind codes
  localparam logic KIND_INDEX   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/bcsrs_ffs.sv =====
// find-first-set unit: position of the lowest set bit of a word
`default_nettype none

module bcsrs_ffs #(
  parameter int WORD_BITS = 32
) (
  input  wire logic [WORD_BITS-1:0]         word_i,
  output logic                              found_o,
  output logic [$clog2(WORD_BITS)-1:0]      index_o
);

  localparam int IdxW = $clog2(WORD_BITS);

  assign found_o = |word_i;

  // scan from the top so the lowest set bit wins
  always_comb begin
    index_o = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word_i[i]) begin
        index_o = IdxW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bit_column_set_row_scanner.sv =====
// top level of the bit column set row scanner
// Takes one column of a bit matrix as a stream of WORD_BITS-wide words, row 0
// first, and returns one index result per set bit in ascending row order; the
// final word of the column (set by column_height) is masked to the height and
// followed by a summary result with the set count, the highest set row and an
// any-set flag. Each word is accepted, then scanned one set bit at a time, then
// closed by a closing step (which issues the summary on the final word); the
// shared find-first-set unit issues one row index per cycle while the output
// is not stalled. The input stalls while a word is scanned. A result may wait
// in the output register while the next word is taken.
`default_nettype none

module bit_column_set_row_scanner #(
  parameter int WORD_BITS = 32,
  parameter int MAX_ROWS  = 4096
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           column_height_we_i,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0]  column_height_i,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [WORD_BITS-1:0]           column_word_i,
  // output channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                result_kind_o,
  output logic [$clog2(MAX_ROWS)-1:0]         row_index_o,
  output logic [$clog2(MAX_ROWS+1)-1:0]       set_count_o,
  output logic [$clog2(MAX_ROWS)-1:0]         highest_row_o,
  output logic                                any_set_o,
  output logic                                last_o
);

  localparam int HgtW     = $clog2(MAX_ROWS + 1);
  localparam int RowW     = $clog2(MAX_ROWS);
  localparam int IdxW     = $clog2(WORD_BITS);
  localparam int LimW     = $clog2(WORD_BITS + 1);
  localparam int NumWords = (MAX_ROWS + WORD_BITS - 1) / WORD_BITS;
  localparam int BaseW    = $clog2(NumWords * WORD_BITS + 1);
  localparam int CmpW     = ((BaseW > HgtW) ? BaseW : HgtW) + 1;

  bcsrs_pkg::state_e state_q, state_d;

  logic [HgtW-1:0]      height_q;
  logic [BaseW-1:0]     base_q, base_d;
  logic [HgtW-1:0]      count_q, count_d;
  logic [RowW-1:0]      highest_q, highest_d;
  logic                 seen_q, seen_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic                 final_q, final_d;

  logic                 out_valid_q, out_valid_d;
  logic                 kind_q, kind_d;
  logic [RowW-1:0]      row_q, row_d;
  logic [HgtW-1:0]      sum_count_q, sum_count_d;
  logic [RowW-1:0]      sum_high_q, sum_high_d;
  logic                 any_q, any_d;
  logic                 last_q, last_d;

  logic [HgtW-1:0]      h_eff;
  logic [CmpW-1:0]      base_ext, h_ext;
  logic                 is_final;
  logic [LimW-1:0]      lim;
  logic [WORD_BITS-1:0] mask;
  logic                 accept;
  logic                 out_free;
  logic                 ffs_found;
  logic [IdxW-1:0]      ffs_index;
  logic [CmpW-1:0]      row_sum;

  bcsrs_ffs #(
    .WORD_BITS (WORD_BITS)
  ) u_ffs (
    .word_i  (word_q),
    .found_o (ffs_found),
    .index_o (ffs_index)
  );

  // clamp the height into 1..MAX_ROWS
  always_comb begin
    h_eff = height_q;
    if (height_q == '0) begin
      h_eff = HgtW'(1);
    end else if (height_q > HgtW'(MAX_ROWS)) begin
      h_eff = HgtW'(MAX_ROWS);
    end
  end

  // final word when the height ends inside or before this word
  assign base_ext = CmpW'(base_q);
  assign h_ext    = CmpW'(h_eff);
  assign is_final = (base_ext + CmpW'(WORD_BITS)) >= h_ext;

  always_comb begin
    if (!is_final) begin
      lim = LimW'(WORD_BITS);
    end else if (base_ext >= h_ext) begin
      lim = '0;
    end else begin
      lim = LimW'(h_ext - base_ext);
    end
    for (int q = 0; q < WORD_BITS; q++) begin
      mask[q] = LimW'(q) < lim;
    end
  end

  assign accept   = in_valid_i && (state_q == bcsrs_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign row_sum  = base_ext + CmpW'(ffs_index);

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    count_d     = count_q;
    highest_d   = highest_q;
    seen_d      = seen_q;
    word_d      = word_q;
    final_d     = final_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    row_d       = row_q;
    sum_count_d = sum_count_q;
    sum_high_d  = sum_high_q;
    any_d       = any_q;
    last_d      = last_q;

    case (state_q)
      bcsrs_pkg::ST_IDLE: begin
        if (accept) begin
          word_d  = column_word_i & mask;
          final_d = is_final;
          state_d = bcsrs_pkg::ST_SCAN;
        end
      end
      bcsrs_pkg::ST_SCAN: begin
        if (out_free) begin
          if (ffs_found) begin
            // issue the lowest remaining set bit and clear it
            out_valid_d = 1'b1;
            kind_d      = bcsrs_pkg::KIND_INDEX;
            row_d       = row_sum[RowW-1:0];
            sum_count_d = '0;
            sum_high_d  = '0;
            any_d       = 1'b0;
            last_d      = 1'b0;
            word_d      = word_q & (word_q - WORD_BITS'(1));
            count_d     = count_q + HgtW'(1);
            highest_d   = row_sum[RowW-1:0];
            seen_d      = 1'b1;
          end else if (final_q) begin
            out_valid_d = 1'b1;
            kind_d      = bcsrs_pkg::KIND_SUMMARY;
            row_d       = '0;
            sum_count_d = count_q;
            sum_high_d  = highest_q;
            any_d       = seen_q;
            last_d      = 1'b1;
            base_d      = '0;
            count_d     = '0;
            highest_d   = '0;
            seen_d      = 1'b0;
            state_d     = bcsrs_pkg::ST_IDLE;
          end else begin
            base_d  = base_q + BaseW'(WORD_BITS);
            state_d = bcsrs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = bcsrs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcsrs_pkg::ST_IDLE;
      height_q    <= HgtW'(32);
      base_q      <= '0;
      count_q     <= '0;
      highest_q   <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      count_q     <= count_d;
      highest_q   <= highest_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
      if (column_height_we_i) begin
        height_q <= column_height_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q      <= word_d;
    final_q     <= final_d;
    kind_q      <= kind_d;
    row_q       <= row_d;
    sum_count_q <= sum_count_d;
    sum_high_q  <= sum_high_d;
    any_q       <= any_d;
    last_q      <= last_d;
  end

  assign in_stall_o    = (state_q != bcsrs_pkg::ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign row_index_o   = row_q;
  assign set_count_o   = sum_count_q;
  assign highest_row_o = sum_high_q;
  assign any_set_o     = any_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire
